[rtl/core/tmadc_pkg.sv]
// ----------------------------------------------------------------------------
// tmadc_pkg
// Shared types, widths and constants of the multichannel trimmed-mean filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tmadc_pkg;

  localparam int DEF_MAX_CHANNELS = 8;
  localparam int DEF_MAX_SAMPLES  = 32;

  localparam int SAMPLE_W    = 16;
  localparam int VREF_W      = 16;
  localparam int FS_W        = 17;
  localparam int CHAN_OUT_W  = 3;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;

  // effective counts are compared at this width (holds MAX_SAMPLES plus one)
  localparam int CNT_W = 9;

  // shared divider: 32-bit dividend, 17-bit divisor
  localparam int DIV_W     = 32;
  localparam int DIVISOR_W = 17;

  localparam logic [SAMPLE_W-1:0] SAT_VALUE = 16'hFFFF;

  localparam logic [3:0]        RST_CHANNELS = 4'd1;
  localparam logic [5:0]        RST_SAMPLES  = 6'd1;
  localparam logic [VREF_W-1:0] RST_VREF     = 16'd3300;
  localparam logic [FS_W-1:0]   RST_FS       = 17'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE   = 3'd0,
    REG_CHANNELS = 3'd1,
    REG_SAMPLES  = 3'd2,
    REG_VREF     = 3'd3,
    REG_FS       = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_MEAN_WAIT,
    ST_SCALE,
    ST_MV,
    ST_MV_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic update;
    logic div_start_mean;
    logic scale;
    logic div_start_mv;
    logic load_out;
    logic next_ch;
    logic clear_batch;
  } ctrl_cmd_t;

  typedef struct packed {
    logic enabled;
    logic batch_end;
    logic last_ch;
    logic div_done;
    logic out_full;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/core/multichannel_trimmed_mean_adc.sv]
// ----------------------------------------------------------------------------
// multichannel_trimmed_mean_adc
// Trimmed-mean filter over interleaved ADC channels with millivolt scaling.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while no batch is being finished, each one
// updating the sum, minimum and maximum of its channel in that cycle. After the
// last sample of a batch the input stalls while each channel in turn goes
// through the shared bit-serial divider twice (trimmed mean, then millivolts);
// each channel's time is set by the two 32-step divisions, plus any wait for
// the result register to be taken. The input reopens after the last result
// is loaded. Samples arriving while disabled are taken and dropped.
`default_nettype none

module multichannel_trimmed_mean_adc #(
  parameter int MAX_CHANNELS = tmadc_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_SAMPLES  = tmadc_pkg::DEF_MAX_SAMPLES
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  input  wire  [tmadc_pkg::SAMPLE_W-1:0]      s_tdata,   // [15:0] sample
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // [2:0] channel, [18:3] filtered_raw, [34:19] millivolts, [39:35] zero
  output logic [tmadc_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                                m_tlast,   // batch_last
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [tmadc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [tmadc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  tmadc_pkg::ctrl_cmd_t  cmd;
  tmadc_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  tmadc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tmadc_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_SAMPLES  (MAX_SAMPLES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .sample    (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // a waiting result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(m_tvalid && !m_tready))
    else $error("result register overwritten while a request waits");

  // divisions only run while the input is closed
  assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> !s_tready)
    else $error("divider finished while samples are being taken");

  // at most one datapath action per cycle
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.update, cmd.div_start_mean, cmd.scale, cmd.div_start_mv, cmd.load_out}))
    else $error("conflicting datapath commands");

  // a sample is only folded in when one is taken
  assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> (s_tvalid && s_tready && status.enabled))
    else $error("accumulator update without an accepted sample");

endmodule

`default_nettype wire

[rtl/core/tmadc_div.sv]
// ----------------------------------------------------------------------------
// tmadc_div
// Restoring divider, one quotient bit per cycle, done pulse after the last bit.
// ----------------------------------------------------------------------------
`default_nettype none

module tmadc_div (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  input  wire  [tmadc_pkg::DIV_W-1:0]         dividend,
  input  wire  [tmadc_pkg::DIVISOR_W-1:0]     divisor,
  output logic [tmadc_pkg::DIV_W-1:0]         quotient,
  output logic                                done
);

  localparam int DW  = tmadc_pkg::DIV_W;
  localparam int RW  = tmadc_pkg::DIVISOR_W;
  localparam int CW  = $clog2(DW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [RW-1:0] rem;
  logic [RW-1:0] dvs;
  logic [RW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem, quotient[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (ge) begin
        rem <= RW'(rem_sh - {1'b0, dvs});
      end else begin
        rem <= rem_sh[RW-1:0];
      end
      quotient <= {quotient[DW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

[rtl/core/tmadc_datapath.sv]
// ----------------------------------------------------------------------------
// tmadc_datapath
// Configuration registers, per-channel accumulators, scaling and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tmadc_datapath #(
  parameter int MAX_CHANNELS = tmadc_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_SAMPLES  = tmadc_pkg::DEF_MAX_SAMPLES
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire tmadc_pkg::ctrl_cmd_t             cmd,
  output tmadc_pkg::dp_status_t                 status,
  input  wire  [tmadc_pkg::SAMPLE_W-1:0]        sample,
  input  wire                                   cfg_valid,
  input  wire  [tmadc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [tmadc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  output logic [tmadc_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                  m_tlast
);

  localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SP_W     = $clog2(MAX_SAMPLES + 1);
  localparam int SW       = tmadc_pkg::SAMPLE_W;
  localparam int SUM_W    = SW + $clog2(MAX_SAMPLES);
  localparam int CNT_W    = tmadc_pkg::CNT_W;
  localparam int DW       = tmadc_pkg::DIV_W;
  localparam int RW       = tmadc_pkg::DIVISOR_W;

  // configuration
  logic                         enable;
  logic [3:0]                   chan_count;
  logic [5:0]                   smp_count;
  logic [tmadc_pkg::VREF_W-1:0] vref_mv;
  logic [tmadc_pkg::FS_W-1:0]   full_scale;

  logic [CNT_W-1:0] cc_ext;
  logic [CNT_W-1:0] sc_ext;
  logic [CNT_W-1:0] nch;
  logic [CNT_W-1:0] nsmp;

  // per-channel accumulators
  logic [SUM_W-1:0]        sum_mem [MAX_CHANNELS];
  logic [SW-1:0]           min_mem [MAX_CHANNELS];
  logic [SW-1:0]           max_mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] ent_valid;

  logic [CH_IDX_W-1:0] chpos;
  logic [SP_W-1:0]     spos;

  logic [SUM_W-1:0] rd_sum;
  logic [SW-1:0]    rd_min;
  logic [SW-1:0]    rd_max;
  logic [SUM_W-1:0] new_sum;
  logic             ch_wrap;
  logic             smp_wrap;
  logic             cfg_we;
  logic             restart;

  // scaling
  logic [SUM_W-1:0] mean_num;
  logic [RW-1:0]    mean_den;
  logic [DW-1:0]    div_dividend;
  logic [RW-1:0]    div_divisor;
  logic [DW-1:0]    quotient;
  logic             div_done;
  logic [SW-1:0]    filt;
  logic [DW-1:0]    prod;
  logic [SW-1:0]    mv_sat;

  // result register
  logic [tmadc_pkg::CHAN_OUT_W-1:0] out_chan;
  logic [SW-1:0]                    out_raw;
  logic [SW-1:0]                    out_mv;

  assign cc_ext = CNT_W'(chan_count);
  assign sc_ext = CNT_W'(smp_count);

  always_comb begin
    priority if (cc_ext == '0) nch = CNT_W'(1);
    else if (cc_ext > CNT_W'(MAX_CHANNELS)) nch = CNT_W'(MAX_CHANNELS);
    else nch = cc_ext;
    priority if (sc_ext == '0) nsmp = CNT_W'(1);
    else if (sc_ext > CNT_W'(MAX_SAMPLES)) nsmp = CNT_W'(MAX_SAMPLES);
    else nsmp = sc_ext;
  end

  // entries not touched since the last restart or batch clear read as their cleared values
  assign rd_sum = ent_valid[chpos] ? sum_mem[chpos] : '0;
  assign rd_min = ent_valid[chpos] ? min_mem[chpos] : tmadc_pkg::SAT_VALUE;
  assign rd_max = ent_valid[chpos] ? max_mem[chpos] : '0;
  assign new_sum = rd_sum + SUM_W'(sample);

  assign ch_wrap  = (CNT_W'(chpos) + CNT_W'(1)) == nch;
  assign smp_wrap = (CNT_W'(spos) + CNT_W'(1)) == nsmp;

  assign cfg_we  = cfg_valid;
  assign restart = cfg_we &&
                   (((cfg_index == tmadc_pkg::REG_ENABLE) && cfg_data[0] && !enable) ||
                    (cfg_index == tmadc_pkg::REG_CHANNELS) ||
                    (cfg_index == tmadc_pkg::REG_SAMPLES));

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      chan_count <= tmadc_pkg::RST_CHANNELS;
      smp_count  <= tmadc_pkg::RST_SAMPLES;
      vref_mv    <= tmadc_pkg::RST_VREF;
      full_scale <= tmadc_pkg::RST_FS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tmadc_pkg::REG_ENABLE:   enable     <= cfg_data[0];
        tmadc_pkg::REG_CHANNELS: chan_count <= cfg_data[3:0];
        tmadc_pkg::REG_SAMPLES:  smp_count  <= cfg_data[5:0];
        tmadc_pkg::REG_VREF:     vref_mv    <= cfg_data[tmadc_pkg::VREF_W-1:0];
        tmadc_pkg::REG_FS:       full_scale <= cfg_data[tmadc_pkg::FS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chpos     <= '0;
      spos      <= '0;
      ent_valid <= '0;
    end else if (restart || cmd.clear_batch) begin
      chpos     <= '0;
      spos      <= '0;
      ent_valid <= '0;
    end else if (cmd.update) begin
      ent_valid[chpos] <= 1'b1;
      if (ch_wrap) begin
        chpos <= '0;
        spos  <= spos + SP_W'(1);
      end else begin
        chpos <= chpos + CH_IDX_W'(1);
      end
    end else if (cmd.next_ch) begin
      chpos <= chpos + CH_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      sum_mem[chpos] <= new_sum;
      min_mem[chpos] <= (sample < rd_min) ? sample : rd_min;
      max_mem[chpos] <= (sample > rd_max) ? sample : rd_max;
    end
  end

  // trimmed mean drops min and max once a channel has more than two samples
  always_comb begin
    if (nsmp <= CNT_W'(2)) begin
      mean_num = rd_sum;
      mean_den = RW'(nsmp);
    end else begin
      mean_num = rd_sum - SUM_W'(rd_min) - SUM_W'(rd_max);
      mean_den = RW'(nsmp - CNT_W'(2));
    end
  end

  assign div_dividend = cmd.div_start_mv ? prod : DW'(mean_num);
  assign div_divisor  = cmd.div_start_mv ? full_scale : mean_den;

  tmadc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start_mean | cmd.div_start_mv),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      filt <= quotient[SW-1:0];
      prod <= DW'(quotient[SW-1:0]) * DW'(vref_mv);
    end
  end

  always_comb begin
    if (full_scale == '0) begin
      mv_sat = '0;
    end else if (quotient[DW-1:SW] != '0) begin
      mv_sat = tmadc_pkg::SAT_VALUE;
    end else begin
      mv_sat = quotient[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_chan <= tmadc_pkg::CHAN_OUT_W'(chpos);
      out_raw  <= filt;
      out_mv   <= mv_sat;
      m_tlast  <= ch_wrap;
    end
  end

  assign m_tdata = tmadc_pkg::OUT_TDATA_W'({out_mv, out_raw, out_chan});

  assign status.enabled   = enable;
  assign status.batch_end = ch_wrap && smp_wrap;
  assign status.last_ch   = ch_wrap;
  assign status.div_done  = div_done;
  assign status.out_full  = m_tvalid && !m_tready;

endmodule

`default_nettype wire

[rtl/core/tmadc_ctrl.sv]
// ----------------------------------------------------------------------------
// tmadc_ctrl
// Sequencer: takes samples, then walks the channels through mean, scale, output.
// ----------------------------------------------------------------------------
`default_nettype none

module tmadc_ctrl (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         s_tvalid,
  output logic                        s_tready,
  input  wire tmadc_pkg::dp_status_t  status,
  output tmadc_pkg::ctrl_cmd_t        cmd
);

  tmadc_pkg::state_t state;
  tmadc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmadc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      tmadc_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        // requests taken while disabled are dropped
        if (s_tvalid && status.enabled) begin
          cmd.update = 1'b1;
          if (status.batch_end) state_next = tmadc_pkg::ST_MEAN;
        end
      end
      tmadc_pkg::ST_MEAN: begin
        cmd.div_start_mean = 1'b1;
        state_next         = tmadc_pkg::ST_MEAN_WAIT;
      end
      tmadc_pkg::ST_MEAN_WAIT: begin
        if (status.div_done) state_next = tmadc_pkg::ST_SCALE;
      end
      tmadc_pkg::ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = tmadc_pkg::ST_MV;
      end
      tmadc_pkg::ST_MV: begin
        cmd.div_start_mv = 1'b1;
        state_next       = tmadc_pkg::ST_MV_WAIT;
      end
      tmadc_pkg::ST_MV_WAIT: begin
        if (status.div_done) state_next = tmadc_pkg::ST_OUT;
      end
      tmadc_pkg::ST_OUT: begin
        if (!status.out_full) begin
          cmd.load_out = 1'b1;
          if (status.last_ch) begin
            cmd.clear_batch = 1'b1;
            state_next      = tmadc_pkg::ST_IDLE;
          end else begin
            cmd.next_ch = 1'b1;
            state_next  = tmadc_pkg::ST_MEAN;
          end
        end
      end
      default: state_next = tmadc_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multichannel trimmed-mean ADC filter.
// ----------------------------------------------------------------------------
// A predictor follows the batch accumulators and register settings, so it
// works out the per-channel results of every accepted sample. A monitor
// checks each result request against the oldest prediction. Directed tests
// cover the extremes, the scaling corners and the restart rules. Random
// batches then run with and without idling on both sides, and one test
// holds off the receiver so that the input stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_CH          = tmadc_pkg::DEF_MAX_CHANNELS;
  localparam int MAX_SMP         = tmadc_pkg::DEF_MAX_SAMPLES;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int SETTLE_CYCLES   = 20;
  localparam int TAIL_CYCLES     = 200;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int REPORT_LIMIT    = 10;
  localparam logic [tmadc_pkg::CFG_IDX_W-1:0] FIRST_UNUSED_REG = 3'd5;

  typedef struct packed {
    logic [tmadc_pkg::CHAN_OUT_W-1:0] channel;
    logic [tmadc_pkg::SAMPLE_W-1:0]   filtered_raw;
    logic [tmadc_pkg::SAMPLE_W-1:0]   millivolts;
    logic                             batch_last;
  } adc_result_t;

  logic                              clk       = 1'b0;
  logic                              rst       = 1'b1;
  logic                              s_tvalid  = 1'b0;
  logic                              s_tready;
  logic [tmadc_pkg::SAMPLE_W-1:0]    s_tdata   = '0;
  logic                              m_tvalid;
  logic                              m_tready  = 1'b0;
  logic [tmadc_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                              m_tlast;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [tmadc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [tmadc_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  multichannel_trimmed_mean_adc dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of registers and batch accumulators
  logic                           cfg_enable   = 1'b0;
  logic [3:0]                     cfg_channels = tmadc_pkg::RST_CHANNELS;
  logic [5:0]                     cfg_samples  = tmadc_pkg::RST_SAMPLES;
  logic [tmadc_pkg::VREF_W-1:0]   cfg_vref     = tmadc_pkg::RST_VREF;
  logic [tmadc_pkg::FS_W-1:0]     cfg_fs       = tmadc_pkg::RST_FS;
  int unsigned                    batch_sum [MAX_CH];
  int unsigned                    batch_min [MAX_CH];
  int unsigned                    batch_max [MAX_CH];
  int unsigned                    next_channel;
  int unsigned                    rounds_seen;

  adc_result_t pending_channel_results[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request   = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned error_count    = 0;
  int unsigned quiet_cycles   = 0;

  function automatic void log_failure(input string msg);
    if (error_count < REPORT_LIMIT) $display("%0t: %s", $time, msg);
    error_count++;
  endfunction

  function automatic void clear_batch();
    for (int i = 0; i < MAX_CH; i++) begin
      batch_sum[i] = 0;
      batch_min[i] = 32'hFFFF;
      batch_max[i] = 0;
    end
    next_channel = 0;
    rounds_seen  = 0;
  endfunction

  function automatic int unsigned effective_channels(input logic [3:0] code);
    if (code == 0) return 1;
    if (code > MAX_CH) return MAX_CH;
    return 32'(code);
  endfunction

  function automatic int unsigned effective_samples(input logic [5:0] code);
    if (code == 0) return 1;
    if (code > MAX_SMP) return MAX_SMP;
    return 32'(code);
  endfunction

  function automatic void apply_register_write(
      input logic [tmadc_pkg::CFG_IDX_W-1:0] idx,
      input logic [tmadc_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      tmadc_pkg::REG_ENABLE: begin
        if (data[0] && !cfg_enable) clear_batch();
        cfg_enable = data[0];
      end
      tmadc_pkg::REG_CHANNELS: begin
        cfg_channels = data[3:0];
        clear_batch();
      end
      tmadc_pkg::REG_SAMPLES: begin
        cfg_samples = data[5:0];
        clear_batch();
      end
      tmadc_pkg::REG_VREF: cfg_vref = data[tmadc_pkg::VREF_W-1:0];
      tmadc_pkg::REG_FS:   cfg_fs = data[tmadc_pkg::FS_W-1:0];
      default: ;
    endcase
  endfunction

  // folds one sample into its channel; at batch end queues one result per channel
  function automatic void accumulate_sample(input logic [tmadc_pkg::SAMPLE_W-1:0] value);
    int unsigned       nch;
    int unsigned       nsmp;
    int unsigned       ch;
    int unsigned       mean;
    longint unsigned   scaled;
    adc_result_t       res;
    if (!cfg_enable) return;
    nch  = effective_channels(cfg_channels);
    nsmp = effective_samples(cfg_samples);
    ch = next_channel;
    if (ch >= nch) ch = nch - 1;
    batch_sum[ch] += 32'(value);
    if (value < batch_min[ch]) batch_min[ch] = 32'(value);
    if (value > batch_max[ch]) batch_max[ch] = 32'(value);
    next_channel = ch + 1;
    if (next_channel < nch) return;
    next_channel = 0;
    rounds_seen++;
    if (rounds_seen < nsmp) return;
    for (ch = 0; ch < nch; ch++) begin
      if (nsmp <= 2) mean = batch_sum[ch] / nsmp;
      else mean = (batch_sum[ch] - batch_min[ch] - batch_max[ch]) / (nsmp - 2);
      mean = mean & 32'hFFFF;
      if (cfg_fs == 0) begin
        scaled = 0;
      end else begin
        scaled = 64'(mean);
        scaled = scaled * 64'(cfg_vref);
        scaled = scaled / 64'(cfg_fs);
        if (scaled > 64'hFFFF) scaled = 64'hFFFF;
      end
      res.channel      = tmadc_pkg::CHAN_OUT_W'(ch);
      res.filtered_raw = tmadc_pkg::SAMPLE_W'(mean);
      res.millivolts   = tmadc_pkg::SAMPLE_W'(scaled);
      res.batch_last   = (ch + 1 == nch);
      pending_channel_results.push_back(res);
    end
    clear_batch();
  endfunction

  function automatic logic [tmadc_pkg::SAMPLE_W-1:0] random_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 20) return tmadc_pkg::SAT_VALUE;
    if (pick < 45) return tmadc_pkg::SAMPLE_W'($urandom_range(2100, 1900));
    return tmadc_pkg::SAMPLE_W'($urandom_range(65535));
  endfunction

  // valid stays high into the next request unless the sender goes idle first
  task automatic send_sample(input logic [tmadc_pkg::SAMPLE_W-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    accumulate_sample(value);
  endtask

  // more keeps cfg_valid high for a following write in the same burst
  task automatic write_reg(input logic [tmadc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tmadc_pkg::CFG_DATA_W-1:0] data,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register_write(idx, data);
    if (!more) cfg_valid <= 1'b0;
  endtask

  task automatic wait_until_idle();
    s_tvalid <= 1'b0;
    while (pending_channel_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // unused upper bits of the write data carry random values
  task automatic set_geometry(input logic [3:0] ch_code, input logic [5:0] smp_code);
    logic [tmadc_pkg::CFG_DATA_W-1:0] data;
    wait_until_idle();
    data = tmadc_pkg::CFG_DATA_W'($urandom);
    data[3:0] = ch_code;
    write_reg(tmadc_pkg::REG_CHANNELS, data, 1'b1);
    data = tmadc_pkg::CFG_DATA_W'($urandom);
    data[5:0] = smp_code;
    write_reg(tmadc_pkg::REG_SAMPLES, data, 1'b0);
  endtask

  task automatic set_scale(input logic [tmadc_pkg::VREF_W-1:0] vref,
                           input logic [tmadc_pkg::FS_W-1:0] fs);
    logic [tmadc_pkg::CFG_DATA_W-1:0] data;
    wait_until_idle();
    data = tmadc_pkg::CFG_DATA_W'($urandom);
    data[tmadc_pkg::VREF_W-1:0] = vref;
    write_reg(tmadc_pkg::REG_VREF, data, 1'b1);
    write_reg(tmadc_pkg::REG_FS, fs, 1'b0);
  endtask

  task automatic set_enable(input logic on);
    logic [tmadc_pkg::CFG_DATA_W-1:0] data;
    wait_until_idle();
    data = tmadc_pkg::CFG_DATA_W'($urandom);
    data[0] = on;
    write_reg(tmadc_pkg::REG_ENABLE, data, 1'b0);
  endtask

  task automatic test_disabled_then_defaults();
    repeat (3) send_sample(random_sample());
    set_enable(1'b1);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0FFF);
    send_sample(16'h8001);
  endtask

  task automatic test_trimmed_mean();
    set_geometry(4'd2, 6'd3);
    send_sample(16'h0000);
    send_sample(16'h8000);
    send_sample(16'hFFFF);
    send_sample(16'h8000);
    send_sample(16'h1234);
    send_sample(16'h8001);
    // two samples per channel fall back to the plain mean
    set_geometry(4'd1, 6'd2);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
  endtask

  task automatic test_scaling();
    set_geometry(4'd1, 6'd1);
    set_scale(16'd3300, 17'd0);
    send_sample(16'hFFFF);
    set_scale(16'hFFFF, 17'd1);
    send_sample(16'h0002);
    set_scale(16'd0, 17'd4096);
    send_sample(16'hFFFF);
    set_scale(16'hFFFF, 17'd65536);
    send_sample(16'hFFFF);
    set_scale(tmadc_pkg::RST_VREF, tmadc_pkg::RST_FS);
  endtask

  task automatic test_count_limits();
    set_geometry(4'd0, 6'd0);
    send_sample(16'hA5A5);
    set_geometry(4'd15, 6'd1);
    for (int i = 0; i < MAX_CH; i++) send_sample(random_sample());
    set_geometry(4'd1, 6'd63);
    for (int i = 0; i < MAX_SMP; i++) send_sample(random_sample());
  endtask

  task automatic test_restart_rules();
    logic [tmadc_pkg::CFG_DATA_W-1:0] data;
    set_geometry(4'd2, 6'd2);
    repeat (3) send_sample(random_sample());
    // rewriting the geometry drops the partial batch
    set_geometry(4'd2, 6'd2);
    repeat (4) send_sample(random_sample());
    send_sample(random_sample());
    set_enable(1'b1);
    repeat (3) send_sample(random_sample());
    send_sample(random_sample());
    set_enable(1'b0);
    repeat (2) send_sample(random_sample());
    set_enable(1'b1);
    repeat (4) send_sample(random_sample());
    send_sample(random_sample());
    wait_until_idle();
    for (int i = int'(FIRST_UNUSED_REG); i < 2 ** tmadc_pkg::CFG_IDX_W; i++) begin
      data = tmadc_pkg::CFG_DATA_W'($urandom);
      write_reg(tmadc_pkg::CFG_IDX_W'(i), data, i + 1 < 2 ** tmadc_pkg::CFG_IDX_W);
    end
    repeat (3) send_sample(random_sample());
  endtask

  task automatic test_output_backpressure();
    set_geometry(4'd4, 6'd2);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    repeat (24) send_sample(random_sample());
    wait_until_idle();
  endtask

  task automatic run_random_segment(input int unsigned target);
    logic [3:0]                       ch_code;
    logic [5:0]                       smp_code;
    logic [tmadc_pkg::VREF_W-1:0]     vref;
    logic [tmadc_pkg::FS_W-1:0]       fs;
    logic [tmadc_pkg::CFG_DATA_W-1:0] data;
    int unsigned                      pick;
    int unsigned                      batch_len;
    int unsigned                      nbatch;
    pick = $urandom_range(99);
    if (pick < 8) smp_code = 6'd0;
    else if (pick < 16) smp_code = 6'($urandom_range(63, 33));
    else if (pick < 22) smp_code = 6'(MAX_SMP);
    else smp_code = 6'($urandom_range(6, 1));
    pick = $urandom_range(99);
    // long batches only with few channels
    if (smp_code > 6) ch_code = 4'($urandom_range(2, 0));
    else if (pick < 12) ch_code = 4'($urandom_range(15, 9));
    else ch_code = 4'($urandom_range(8, 0));
    pick = $urandom_range(99);
    if (pick < 15) vref = 16'd0;
    else if (pick < 30) vref = 16'hFFFF;
    else if (pick < 45) vref = tmadc_pkg::RST_VREF;
    else vref = tmadc_pkg::VREF_W'($urandom_range(65535));
    pick = $urandom_range(99);
    if (pick < 10) fs = 17'd0;
    else if (pick < 20) fs = 17'd1;
    else if (pick < 30) fs = 17'd65536;
    else if (pick < 40) fs = 17'h1FFFF;
    else if (pick < 50) fs = tmadc_pkg::RST_FS;
    else fs = tmadc_pkg::FS_W'($urandom_range(131071));

    wait_until_idle();
    data = tmadc_pkg::CFG_DATA_W'($urandom);
    data[3:0] = ch_code;
    write_reg(tmadc_pkg::REG_CHANNELS, data, 1'b1);
    data = tmadc_pkg::CFG_DATA_W'($urandom);
    data[5:0] = smp_code;
    write_reg(tmadc_pkg::REG_SAMPLES, data, 1'b1);
    data = tmadc_pkg::CFG_DATA_W'($urandom);
    data[tmadc_pkg::VREF_W-1:0] = vref;
    write_reg(tmadc_pkg::REG_VREF, data, 1'b1);
    write_reg(tmadc_pkg::REG_FS, fs, 1'b1);
    data = tmadc_pkg::CFG_DATA_W'($urandom);
    data[0] = 1'b1;
    write_reg(tmadc_pkg::REG_ENABLE, data, 1'b0);

    batch_len = effective_channels(ch_code) * effective_samples(smp_code);
    nbatch = target / batch_len;
    if (nbatch == 0) nbatch = 1;

    // broken sequence: up to one full batch, then a disable or a geometry write
    pick = $urandom_range(99);
    if (pick < 25) begin
      repeat ($urandom_range(batch_len, 1)) send_sample(random_sample());
      if (pick < 12) begin
        set_enable(1'b0);
        repeat (3) send_sample(random_sample());
        set_enable(1'b1);
      end else begin
        wait_until_idle();
        data = tmadc_pkg::CFG_DATA_W'($urandom);
        data[5:0] = smp_code;
        write_reg(tmadc_pkg::REG_SAMPLES, data, 1'b0);
      end
    end
    repeat (nbatch * batch_len) send_sample(random_sample());
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      run_random_segment(12);
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // receiver: random stalls, plus a long hold-off counted here on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    adc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_channel_results.size() == 0) begin
        log_failure($sformatf("unexpected result: ch %0d raw %0d mv %0d last %0b",
                              m_tdata[2:0], m_tdata[18:3], m_tdata[34:19], m_tlast));
      end else begin
        want = pending_channel_results.pop_front();
        if (m_tdata[2:0] !== want.channel || m_tdata[18:3] !== want.filtered_raw ||
            m_tdata[34:19] !== want.millivolts || m_tlast !== want.batch_last ||
            m_tdata[39:35] !== '0) begin
          log_failure({
            $sformatf("result error: want ch %0d raw %0d mv %0d last %0b, ",
                      want.channel, want.filtered_raw, want.millivolts,
                      want.batch_last),
            $sformatf("got ch %0d raw %0d mv %0d last %0b pad %h",
                      m_tdata[2:0], m_tdata[18:3], m_tdata[34:19], m_tlast,
                      m_tdata[39:35])});
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no request moved for %0d cycles", $time, quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    clear_batch();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_disabled_then_defaults();
    test_trimmed_mean();
    test_scaling();
    test_count_limits();
    test_restart_rules();
    test_output_backpressure();
    test_random_traffic();
    wait_until_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_channel_results.size() != 0)
      log_failure($sformatf("%0d results never arrived", pending_channel_results.size()));
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/tmadc_pkg.sv
rtl/core/tmadc_div.sv
rtl/core/tmadc_datapath.sv
rtl/core/tmadc_ctrl.sv
rtl/core/multichannel_trimmed_mean_adc.sv
tb/testbench.sv
